[hdl/pil_pkg.sv]
// Package for the positional insert list: shared constants, status codes and result type.
// No dependencies; used by pil_ctrl, the top level and the checker.
package pil_pkg;

  // Default list capacity
  localparam int CAPACITY_DEF = 16;

  // Field widths
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 5;

  // Transaction kinds (carried on in_tuser)
  localparam logic KIND_READ   = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // One result between the sequencer and the output register
  typedef struct packed {
    logic [LEN_W-1:0]    list_length;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  read_value;
  } pil_result_t;

endpackage

[hdl/pil_ram.sv]
// Generic single-clock RAM: one write port, one read port with registered read data.
// No dependencies.
module pil_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic                             rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/pil_ctrl.sv]
// Sequencer of the positional insert list: checks each transaction, walks the element
// RAM for reads and shifting inserts, and keeps the list length. Depends on pil_pkg.
module pil_ctrl #(
  parameter int CAPACITY = pil_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // incoming transaction
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_kind,
  input  logic [pil_pkg::POS_W-1:0]         in_pos,
  input  logic [pil_pkg::VALUE_W-1:0]       in_value,
  // element RAM
  output logic                              ram_rd_en,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] ram_rd_addr,
  input  logic [pil_pkg::VALUE_W-1:0]       ram_rd_data,
  output logic                              ram_wr_en,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] ram_wr_addr,
  output logic [pil_pkg::VALUE_W-1:0]       ram_wr_data,
  // finished result
  output logic                              res_valid,
  input  logic                              res_ready,
  output pil_pkg::pil_result_t              res
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = ((CW > pil_pkg::POS_W) ? CW : pil_pkg::POS_W) + 1;
  localparam logic [LW-1:0] CapL = LW'(CAPACITY);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RDATA = 5'b00010,
    S_SHIFT = 5'b00100,
    S_PUT   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [AW-1:0]                idx_r, idx_nxt;
  logic [AW-1:0]                pos_m1_r, pos_m1_nxt;
  logic [pil_pkg::VALUE_W-1:0]  value_r, value_nxt;
  pil_pkg::pil_result_t         res_r, res_nxt;

  logic [LW-1:0] pos_l, cnt_l, cnt_p1_l, cnt_m1_l, pos_m1_l;
  logic          pos_zero, rd_ok, ins_pos_ok, full, no_shift;

  // Position checks against the current length
  always_comb begin
    pos_l      = LW'(in_pos);
    cnt_l      = LW'(count_r);
    cnt_p1_l   = cnt_l + LW'(1);
    cnt_m1_l   = cnt_l - LW'(1);
    pos_m1_l   = pos_l - LW'(1);
    pos_zero   = (in_pos == '0);
    rd_ok      = !pos_zero && (pos_l <= cnt_l);
    ins_pos_ok = !pos_zero && (pos_l <= cnt_p1_l);
    full       = (cnt_l >= CapL);
    no_shift   = (pos_m1_l == cnt_l);
  end

  // Next-state logic and RAM access sequencing
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    pos_m1_nxt  = pos_m1_r;
    value_nxt   = value_r;
    res_nxt     = res_r;
    ram_rd_en   = 1'b0;
    ram_rd_addr = '0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = idx_r;
    ram_wr_data = ram_rd_data;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pos_m1_nxt          = pos_m1_l[AW-1:0];
          value_nxt           = in_value;
          res_nxt.read_value  = '0;
          res_nxt.status      = pil_pkg::ST_OK;
          res_nxt.list_length = cnt_l[pil_pkg::LEN_W-1:0];
          if (in_kind == pil_pkg::KIND_READ) begin
            if (rd_ok) begin
              ram_rd_en   = 1'b1;
              ram_rd_addr = pos_m1_l[AW-1:0];
              state_nxt   = S_RDATA;
            end else begin
              res_nxt.status = pil_pkg::ST_RANGE;
              state_nxt      = S_DONE;
            end
          end else if (!ins_pos_ok) begin
            res_nxt.status = pil_pkg::ST_RANGE;
            state_nxt      = S_DONE;
          end else if (full) begin
            res_nxt.status = pil_pkg::ST_FULL;
            state_nxt      = S_DONE;
          end else if (no_shift) begin
            state_nxt = S_PUT;
          end else begin
            // fetch the last element; it moves to index count
            ram_rd_en   = 1'b1;
            ram_rd_addr = cnt_m1_l[AW-1:0];
            idx_nxt     = cnt_l[AW-1:0];
            state_nxt   = S_SHIFT;
          end
        end
      end

      S_RDATA: begin
        res_nxt.read_value = ram_rd_data;
        state_nxt          = S_DONE;
      end

      // One element per cycle: write idx <- data of idx-1, fetch idx-2
      S_SHIFT: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = idx_r;
        ram_wr_data = ram_rd_data;
        if ((idx_r - AW'(1)) == pos_m1_r) begin
          state_nxt = S_PUT;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = idx_r - AW'(1) - AW'(1);
          idx_nxt     = idx_r - AW'(1);
        end
      end

      S_PUT: begin
        ram_wr_en           = 1'b1;
        ram_wr_addr         = pos_m1_r;
        ram_wr_data         = value_r;
        count_nxt           = cnt_p1_l[CW-1:0];
        res_nxt.list_length = cnt_p1_l[pil_pkg::LEN_W-1:0];
        state_nxt           = S_DONE;
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    pos_m1_r <= pos_m1_nxt;
    value_r  <= value_nxt;
    res_r    <= res_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

endmodule

[hdl/positional_insert_list_top.sv]
// Top level of the positional insert list: sequencer, element RAM and output register.
// Depends on pil_pkg, pil_ram and pil_ctrl.
//
// Holds an ordered list of up to CAPACITY signed 32-bit words in a single-port-write RAM.
// One transaction is worked at a time and gives exactly one result. A read passes through
// the read-data state; a transaction flagged out of range or full goes straight to the done
// state; an insert shifts the tail from position p on up by one, the RAM moving one element
// per cycle, and then writes the new value at p. From the done state the result is loaded
// into the output register. The next transaction is accepted no earlier than the edge after
// the previous result has moved into the output register, which may still be waiting on
// out_tready.
module positional_insert_list_top #(
  parameter int CAPACITY = pil_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input transactions
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [4:0] position, [36:5] value, [39:37] zero
  input  logic        in_tuser,   // [0] kind: 0 read, 1 insert
  // result transactions
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [31:0] read_value, [33:32] status, [38:34] list_length,
                                  // [39] zero
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                        ram_rd_en, ram_wr_en;
  logic [AW-1:0]               ram_rd_addr, ram_wr_addr;
  logic [pil_pkg::VALUE_W-1:0] ram_rd_data, ram_wr_data;
  logic                        res_valid, res_ready;
  pil_pkg::pil_result_t        res;
  logic                        out_valid_r;
  pil_pkg::pil_result_t        out_res_r;

  pil_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_kind     (in_tuser),
    .in_pos      (in_tdata[4:0]),
    .in_value    (in_tdata[36:5]),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  pil_ram #(
    .WIDTH (pil_pkg::VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Output register: frees the sequencer while a result waits downstream
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.list_length, out_res_r.status, out_res_r.read_value};

endmodule

[hdl/pil_checker.sv]
// Port-level checker for the positional insert list, bound to the top level.
// Depends on pil_pkg and positional_insert_list_top.
module pil_checker #(
  parameter int CAPACITY = pil_pkg::CAPACITY_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  localparam logic [pil_pkg::LEN_W-1:0] CapLen = pil_pkg::LEN_W'(CAPACITY);

  // No result is presented right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Error results carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[33:32] != pil_pkg::ST_OK) |-> out_tdata[31:0] == '0)
    else $error("error result with nonzero value");

  // A full report only happens at capacity; status code 3 is never used
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[33:32] == pil_pkg::ST_FULL) |-> out_tdata[38:34] == CapLen)
    else $error("full status with length below capacity");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[33:32] == pil_pkg::ST_OK) ||
                   (out_tdata[33:32] == pil_pkg::ST_RANGE) ||
                   (out_tdata[33:32] == pil_pkg::ST_FULL))
    else $error("undefined status code");

endmodule

bind positional_insert_list_top pil_checker #(
  .CAPACITY (CAPACITY)
) u_pil_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
